// ===== rtl/dbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual bank config save controller package
// Shared widths, event codes, bank codes, save phases and result codes.
// ----------------------------------------------------------------------------
package dbcs_pkg;

   // Width of the saturating dirty age counter.
   localparam int AGE_BITS = 16;
   localparam int DEB_BITS = 16;
   localparam int SEQ_BITS = 32;
   // Common width for the age versus debounce compare.
   localparam int CMP_BITS = (AGE_BITS > DEB_BITS) ? AGE_BITS : DEB_BITS;

   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
   localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 16'd1000;

   typedef logic [2:0] op_type;
   typedef logic [1:0] bank_type;
   typedef logic [1:0] phase_type;
   typedef logic [1:0] result_type;

   // Request event codes.
   localparam op_type OP_TICK  = 3'd0;
   localparam op_type OP_DIRTY = 3'd1;
   localparam op_type OP_SAVE  = 3'd2;
   localparam op_type OP_BOOT  = 3'd3;
   localparam op_type OP_WRITE = 3'd4;
   localparam op_type OP_TAKE  = 3'd5;

   // Active bank and boot choice codes.
   localparam bank_type BANK_NONE = 2'd0;
   localparam bank_type BANK_A    = 2'd1;
   localparam bank_type BANK_B    = 2'd2;

   // Save phases.
   localparam phase_type PH_IDLE   = 2'd0;
   localparam phase_type PH_FIRST  = 2'd1;
   localparam phase_type PH_SECOND = 2'd2;

   // Save result codes.
   localparam result_type RES_NONE   = 2'd0;
   localparam result_type RES_SAVED  = 2'd1;
   localparam result_type RES_FAILED = 2'd2;

endpackage

// ===== rtl/dual_bank_config_save_controller.sv =====
// Response: the response to an accepted request is registered at the clock edge that accepts it
// and is valid from then on; it stays until taken.
// Throughput: one request per cycle while the consumer takes each response; a new request is
// taken while the held response is being taken, so the single response register sets the rate.
// Reset (synchronous, active high): no save in flight, no bank active, sequence zero,
// debounce at 1000 ticks, no response pending.
// ----------------------------------------------------------------------------
// Dual bank configuration save controller
// Decides when a configuration is saved and into which of two alternating
// flash banks, tracks the boot choice, and reports save outcomes.
// ----------------------------------------------------------------------------
module dual_bank_config_save_controller (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic                         req_valid_a,
   input  logic                         req_valid_b,
   input  logic [31:0]                  req_seq_a,
   input  logic [31:0]                  req_seq_b,
   input  logic                         req_write_ok,
   // Response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_write_cmd,
   output logic                         rsp_write_bank,
   output logic [31:0]                  rsp_write_seq,
   output logic [1:0]                   rsp_apply_bank,
   output logic [1:0]                   rsp_result_code,
   output logic                         rsp_busy_res,
   // Configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [15:0]                  csr_debounce_ms
);

   // Controller state. Every field but the debounce register is updated in the
   // cycle its request is accepted, so the next request always sees the finished effect.
   logic                              pend_ff,   pend_in;
   logic                              dirty_ff,  dirty_in;
   logic [dbcs_pkg::AGE_BITS-1:0]     age_ff,    age_in;
   dbcs_pkg::bank_type                active_ff, active_in;
   logic [dbcs_pkg::SEQ_BITS-1:0]     seq_ff,    seq_in;
   dbcs_pkg::phase_type               phase_ff,  phase_in;
   logic                              target_ff, target_in;
   dbcs_pkg::result_type              last_ff,   last_in;
   logic [dbcs_pkg::DEB_BITS-1:0]     debounce_ff;

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              wcmd_ff,  wcmd_in;
   logic                              wbank_ff, wbank_in;
   logic [dbcs_pkg::SEQ_BITS-1:0]     wseq_ff,  wseq_in;
   dbcs_pkg::bank_type                apply_ff, apply_in;
   dbcs_pkg::result_type              code_ff,  code_in;
   logic                              busy_ff,  busy_in;

   logic                              req_fire;
   logic                              start;
   dbcs_pkg::bank_type                pick;

   // The response register frees up in the same cycle it is taken, so a
   // request can enter every cycle while the consumer keeps up.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      pend_in   = pend_ff;
      dirty_in  = dirty_ff;
      age_in    = age_ff;
      active_in = active_ff;
      seq_in    = seq_ff;
      phase_in  = phase_ff;
      target_in = target_ff;
      last_in   = last_ff;
      wcmd_in   = 1'b0;
      wbank_in  = 1'b0;
      wseq_in   = '0;
      apply_in  = dbcs_pkg::BANK_NONE;
      code_in   = dbcs_pkg::RES_NONE;
      start     = 1'b0;
      pick      = dbcs_pkg::BANK_NONE;

      if (req_fire) begin
         case (req_op)
            dbcs_pkg::OP_TICK: begin
               // The age saturates instead of wrapping.
               if (age_ff != dbcs_pkg::AGE_MAX) begin
                  age_in = age_ff + 1'b1;
               end
            end
            dbcs_pkg::OP_DIRTY: begin
               dirty_in = 1'b1;
               age_in   = '0;
            end
            dbcs_pkg::OP_SAVE: begin
               pend_in  = 1'b1;
               dirty_in = 1'b1;
            end
            dbcs_pkg::OP_BOOT: begin
               // The valid bank with the higher sequence wins; A wins a tie.
               if (req_valid_a && req_valid_b) begin
                  pick = (req_seq_a >= req_seq_b) ? dbcs_pkg::BANK_A : dbcs_pkg::BANK_B;
               end else if (req_valid_a) begin
                  pick = dbcs_pkg::BANK_A;
               end else if (req_valid_b) begin
                  pick = dbcs_pkg::BANK_B;
               end
               if (pick != dbcs_pkg::BANK_NONE) begin
                  active_in = pick;
                  seq_in    = (pick == dbcs_pkg::BANK_A) ? req_seq_a : req_seq_b;
               end
               apply_in = pick;
            end
            dbcs_pkg::OP_WRITE: begin
               if (phase_ff != dbcs_pkg::PH_IDLE) begin
                  if (req_write_ok) begin
                     active_in = target_ff ? dbcs_pkg::BANK_B : dbcs_pkg::BANK_A;
                     seq_in    = seq_ff + 1'b1;
                     last_in   = dbcs_pkg::RES_SAVED;
                     phase_in  = dbcs_pkg::PH_IDLE;
                  end else if (phase_ff == dbcs_pkg::PH_FIRST) begin
                     // First failure: retry on the other bank.
                     target_in = ~target_ff;
                     phase_in  = dbcs_pkg::PH_SECOND;
                     wcmd_in   = 1'b1;
                     wbank_in  = ~target_ff;
                     wseq_in   = seq_ff + 1'b1;
                  end else begin
                     last_in  = dbcs_pkg::RES_FAILED;
                     phase_in = dbcs_pkg::PH_IDLE;
                  end
               end
            end
            dbcs_pkg::OP_TAKE: begin
               code_in = last_ff;
               last_in = dbcs_pkg::RES_NONE;
            end
            default: begin
            end
         endcase

         // Start check runs after every event while no save is in flight.
         if (phase_in == dbcs_pkg::PH_IDLE) begin
            if (pend_in) begin
               pend_in  = 1'b0;
               dirty_in = 1'b0;
               start    = 1'b1;
            end else if (dirty_in && (dbcs_pkg::CMP_BITS'(age_in) >=
                                      dbcs_pkg::CMP_BITS'(debounce_ff))) begin
               dirty_in = 1'b0;
               start    = 1'b1;
            end
            if (start) begin
               target_in = (active_in == dbcs_pkg::BANK_A);
               phase_in  = dbcs_pkg::PH_FIRST;
               wcmd_in   = 1'b1;
               wbank_in  = target_in;
               wseq_in   = seq_in + 1'b1;
            end
         end
      end

      busy_in      = (phase_in != dbcs_pkg::PH_IDLE);
      rsp_valid_in = req_fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         dirty_ff     <= 1'b0;
         age_ff       <= '0;
         active_ff    <= dbcs_pkg::BANK_NONE;
         seq_ff       <= '0;
         phase_ff     <= dbcs_pkg::PH_IDLE;
         target_ff    <= 1'b0;
         last_ff      <= dbcs_pkg::RES_NONE;
         debounce_ff  <= dbcs_pkg::DEBOUNCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         dirty_ff     <= dirty_in;
         age_ff       <= age_in;
         active_ff    <= active_in;
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         target_ff    <= target_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            debounce_ff <= csr_debounce_ms;
         end
      end
   end

   // Response payload only loads on an accepted request.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         wcmd_ff  <= wcmd_in;
         wbank_ff <= wbank_in;
         wseq_ff  <= wseq_in;
         apply_ff <= apply_in;
         code_ff  <= code_in;
         busy_ff  <= busy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_cmd   = wcmd_ff;
   assign rsp_write_bank  = wbank_ff;
   assign rsp_write_seq   = wseq_ff;
   assign rsp_apply_bank  = apply_ff;
   assign rsp_result_code = code_ff;
   assign rsp_busy_res    = busy_ff;

   // The held busy flag always agrees with the save phase it was taken from.
   a_busy_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (busy_ff == (phase_ff != dbcs_pkg::PH_IDLE)))
      else $error("busy flag disagrees with save phase");

   // A commanded write always leaves a save in flight.
   a_write_means_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && wcmd_ff) |-> busy_ff)
      else $error("write command without a save in flight");

   // A failed fallback write records the failure and ends the save.
   a_second_fail: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == dbcs_pkg::OP_WRITE && phase_ff == dbcs_pkg::PH_SECOND &&
       !req_write_ok) |=> (last_ff == dbcs_pkg::RES_FAILED))
      else $error("second write failure not recorded");

endmodule

// ===== sim/dual_bank_config_save_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Dual bank config save controller testbench
// Drives boot reports, dirty marks, save requests, ticks, write outcomes and
// result reads through the request channel. The debounce register is
// rewritten between phases. Every response is checked against an in-bench
// model of the save decisions, with random stalls on both channels.
// ----------------------------------------------------------------------------
module dual_bank_config_save_controller_tb;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int LIMIT_CYCLES  = 600000;
   localparam int RANDOM_ITEMS  = 300;
   localparam int REPORT_MAX    = 10;
   // Enough ticks to age a dirty mark past a debounce of 100 during a save.
   localparam int AGE_BURST     = 120;

   // Op codes the block does not decode; only the save start check runs.
   localparam dbcs_pkg::op_type OP_SPARE_LO = 3'd6;
   localparam dbcs_pkg::op_type OP_SPARE_HI = 3'd7;

   localparam logic [dbcs_pkg::SEQ_BITS-1:0] SEQ_MAX = {dbcs_pkg::SEQ_BITS{1'b1}};

   typedef struct packed {
      dbcs_pkg::op_type              op;
      logic                          va;
      logic                          vb;
      logic [dbcs_pkg::SEQ_BITS-1:0] sa;
      logic [dbcs_pkg::SEQ_BITS-1:0] sb;
      logic                          ok;
   } req_item_type;

   typedef struct packed {
      logic                          write_cmd;
      logic                          write_bank;
      logic [dbcs_pkg::SEQ_BITS-1:0] write_seq;
      dbcs_pkg::bank_type            apply_bank;
      dbcs_pkg::result_type          result_code;
      logic                          busy;
   } save_decision_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;

   logic                          req_valid    = 1'b0;
   logic                          req_ready;
   dbcs_pkg::op_type              req_op       = dbcs_pkg::OP_TICK;
   logic                          req_valid_a  = 1'b0;
   logic                          req_valid_b  = 1'b0;
   logic [dbcs_pkg::SEQ_BITS-1:0] req_seq_a    = '0;
   logic [dbcs_pkg::SEQ_BITS-1:0] req_seq_b    = '0;
   logic                          req_write_ok = 1'b0;

   logic                          rsp_valid;
   logic                          rsp_ready    = 1'b0;
   logic                          rsp_write_cmd;
   logic                          rsp_write_bank;
   logic [dbcs_pkg::SEQ_BITS-1:0] rsp_write_seq;
   dbcs_pkg::bank_type            rsp_apply_bank;
   dbcs_pkg::result_type          rsp_result_code;
   logic                          rsp_busy_res;

   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [dbcs_pkg::DEB_BITS-1:0] csr_debounce_ms = '0;

   // Percent of cycles in which each side holds off.
   int                  req_gap_pct = 11;
   int                  rsp_gap_pct = 66;
   // Long receiver hold-off, driven by its own process below.
   logic                rsp_hold    = 1'b0;
   logic                hold_arm    = 1'b0;

   int                  mismatch_count = 0;
   int                  cycle_count    = 0;

   req_item_type        event_q[$];
   save_decision_type   expected_decisions[$];

   // Model copy of the controller state and its debounce register.
   logic [dbcs_pkg::DEB_BITS-1:0] debounce_cfg = dbcs_pkg::DEBOUNCE_RESET;
   logic                          ctl_pending  = 1'b0;
   logic                          ctl_dirty    = 1'b0;
   logic [dbcs_pkg::AGE_BITS-1:0] ctl_age      = '0;
   dbcs_pkg::bank_type            ctl_active   = dbcs_pkg::BANK_NONE;
   logic [dbcs_pkg::SEQ_BITS-1:0] ctl_seq      = '0;
   dbcs_pkg::phase_type           ctl_phase    = dbcs_pkg::PH_IDLE;
   logic                          ctl_target   = 1'b0;
   dbcs_pkg::result_type          ctl_last     = dbcs_pkg::RES_NONE;

   dual_bank_config_save_controller u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_valid_a     (req_valid_a),
      .req_valid_b     (req_valid_b),
      .req_seq_a       (req_seq_a),
      .req_seq_b       (req_seq_b),
      .req_write_ok    (req_write_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_cmd   (rsp_write_cmd),
      .rsp_write_bank  (rsp_write_bank),
      .rsp_write_seq   (rsp_write_seq),
      .rsp_apply_bank  (rsp_apply_bank),
      .rsp_result_code (rsp_result_code),
      .rsp_busy_res    (rsp_busy_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_debounce_ms (csr_debounce_ms)
   );

   always #CLK_HALF clock = ~clock;

   // A verified write makes the written bank active and bumps the sequence.
   task automatic commit_save();
      ctl_active = ctl_target ? dbcs_pkg::BANK_B : dbcs_pkg::BANK_A;
      ctl_seq    = ctl_seq + 1'b1;
      ctl_last   = dbcs_pkg::RES_SAVED;
      ctl_phase  = dbcs_pkg::PH_IDLE;
   endtask

   // Applies one accepted request to the model state and queues the response
   // the block must return for it.
   task automatic predict_save_decision(input req_item_type it);
      save_decision_type  d;
      dbcs_pkg::bank_type pick;
      logic               start;
      d     = '0;
      pick  = dbcs_pkg::BANK_NONE;
      start = 1'b0;
      case (it.op)
         dbcs_pkg::OP_TICK: begin
            if (ctl_age != dbcs_pkg::AGE_MAX) ctl_age = ctl_age + 1'b1;
         end
         dbcs_pkg::OP_DIRTY: begin
            ctl_dirty = 1'b1;
            ctl_age   = '0;
         end
         dbcs_pkg::OP_SAVE: begin
            ctl_pending = 1'b1;
            ctl_dirty   = 1'b1;
         end
         dbcs_pkg::OP_BOOT: begin
            // The higher valid sequence wins; bank A takes a tie.
            if (it.va && it.vb)
               pick = (it.sa >= it.sb) ? dbcs_pkg::BANK_A : dbcs_pkg::BANK_B;
            else if (it.va) pick = dbcs_pkg::BANK_A;
            else if (it.vb) pick = dbcs_pkg::BANK_B;
            if (pick != dbcs_pkg::BANK_NONE) begin
               ctl_active = pick;
               ctl_seq    = (pick == dbcs_pkg::BANK_A) ? it.sa : it.sb;
            end
            d.apply_bank = pick;
         end
         dbcs_pkg::OP_WRITE: begin
            if (ctl_phase == dbcs_pkg::PH_FIRST) begin
               if (it.ok) begin
                  commit_save();
               end else begin
                  // First write failed: fall back to the other bank.
                  ctl_target   = ~ctl_target;
                  ctl_phase    = dbcs_pkg::PH_SECOND;
                  d.write_cmd  = 1'b1;
                  d.write_bank = ctl_target;
                  d.write_seq  = ctl_seq + 1'b1;
               end
            end else if (ctl_phase == dbcs_pkg::PH_SECOND) begin
               if (it.ok) begin
                  commit_save();
               end else begin
                  ctl_last  = dbcs_pkg::RES_FAILED;
                  ctl_phase = dbcs_pkg::PH_IDLE;
               end
            end
         end
         dbcs_pkg::OP_TAKE: begin
            d.result_code = ctl_last;
            ctl_last      = dbcs_pkg::RES_NONE;
         end
         default: begin
         end
      endcase

      // Save start check, after every request while no save is in flight.
      if (ctl_phase == dbcs_pkg::PH_IDLE) begin
         if (ctl_pending) begin
            ctl_pending = 1'b0;
            ctl_dirty   = 1'b0;
            start       = 1'b1;
         end else if (ctl_dirty && ctl_age >= debounce_cfg) begin
            ctl_dirty = 1'b0;
            start     = 1'b1;
         end
         if (start) begin
            ctl_target   = (ctl_active == dbcs_pkg::BANK_A);
            ctl_phase    = dbcs_pkg::PH_FIRST;
            d.write_cmd  = 1'b1;
            d.write_bank = ctl_target;
            d.write_seq  = ctl_seq + 1'b1;
         end
      end

      d.busy = (ctl_phase != dbcs_pkg::PH_IDLE);
      expected_decisions.push_back(d);
   endtask

   function automatic req_item_type random_request();
      req_item_type it;
      int           roll;
      it.va = 1'($urandom_range(1));
      it.vb = 1'($urandom_range(1));
      it.sa = $urandom();
      it.sb = $urandom();
      it.ok = ($urandom_range(99) < 65);
      roll  = $urandom_range(99);
      if (roll < 30) it.op = dbcs_pkg::OP_TICK;
      else if (roll < 40) it.op = dbcs_pkg::OP_DIRTY;
      else if (roll < 50) it.op = dbcs_pkg::OP_SAVE;
      else if (roll < 60) it.op = dbcs_pkg::OP_BOOT;
      else if (roll < 82) it.op = dbcs_pkg::OP_WRITE;
      else if (roll < 95) it.op = dbcs_pkg::OP_TAKE;
      else it.op = dbcs_pkg::op_type'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      // Boot reports get ties, wrap-prone and tiny sequences besides random ones.
      if (it.op == dbcs_pkg::OP_BOOT) begin
         case ($urandom_range(3))
            1: it.sb = it.sa;
            2: begin
               it.sa = SEQ_MAX - dbcs_pkg::SEQ_BITS'($urandom_range(3));
               it.sb = SEQ_MAX - dbcs_pkg::SEQ_BITS'($urandom_range(3));
            end
            3: begin
               it.sa = dbcs_pkg::SEQ_BITS'($urandom_range(7));
               it.sb = dbcs_pkg::SEQ_BITS'($urandom_range(7));
            end
            default: begin
            end
         endcase
      end
      return it;
   endfunction

   task automatic push_request(input dbcs_pkg::op_type op, input logic va, input logic vb,
                               input logic [dbcs_pkg::SEQ_BITS-1:0] sa,
                               input logic [dbcs_pkg::SEQ_BITS-1:0] sb, input logic ok);
      req_item_type it;
      it = '{op: op, va: va, vb: vb, sa: sa, sb: sb, ok: ok};
      event_q.push_back(it);
   endtask

   // Sampled at the falling edge, where every update of the rising edge has
   // settled, so the check cannot race the driver.
   task automatic wait_drained();
      @(negedge clock);
      while (event_q.size() != 0 || req_valid || expected_decisions.size() != 0)
         @(negedge clock);
   endtask

   // The debounce register is only rewritten once the block has gone quiet.
   task automatic write_debounce(input logic [dbcs_pkg::DEB_BITS-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_debounce_ms <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      debounce_cfg  = value;
   endtask

   task automatic push_random(input int count);
      repeat (count) event_q.push_back(random_request());
   endtask

   // Request driver. A held request stays put until accepted; after each
   // acceptance the next queued request is offered unless the sender idles.
   always @(posedge clock) begin : drive_requests
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_save_decision('{op: req_op, va: req_valid_a, vb: req_valid_b,
                                    sa: req_seq_a, sb: req_seq_b, ok: req_write_ok});
         end
         if (!req_valid || req_ready) begin
            if (event_q.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               it = event_q.pop_front();
               req_valid    <= 1'b1;
               req_op       <= it.op;
               req_valid_a  <= it.va;
               req_valid_b  <= it.vb;
               req_seq_a    <= it.sa;
               req_seq_b    <= it.sb;
               req_write_ok <= it.ok;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each accepted response is compared with the oldest
   // expected decision; the ready line idles at random or during the hold.
   always @(posedge clock) begin : check_responses
      save_decision_type seen;
      save_decision_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{write_cmd: rsp_write_cmd, write_bank: rsp_write_bank,
                     write_seq: rsp_write_seq, apply_bank: rsp_apply_bank,
                     result_code: rsp_result_code, busy: rsp_busy_res};
            if (expected_decisions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("response with no request waiting: cmd=%0d bank=%0d seq=%h",
                           seen.write_cmd, seen.write_bank, seen.write_seq);
            end else begin
               want = expected_decisions.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX) begin
                     $display("response mismatch at cycle %0d", cycle_count);
                     $display("  expected cmd=%0d bank=%0d seq=%h apply=%0d result=%0d busy=%0d",
                              want.write_cmd, want.write_bank, want.write_seq,
                              want.apply_bank, want.result_code, want.busy);
                     $display("  actual   cmd=%0d bank=%0d seq=%h apply=%0d result=%0d busy=%0d",
                              seen.write_cmd, seen.write_bank, seen.write_seq,
                              seen.apply_bank, seen.result_code, seen.busy);
                  end
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   // Long receiver hold-off while the sender keeps offering requests, so the
   // single response register fills and the request channel backs up.
   initial begin
      wait (hold_arm);
      repeat (40) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset debounce of 1000 ticks.
      push_request(dbcs_pkg::OP_TAKE,  1'b0, 1'b0, '0, '0, 1'b0);       // nothing new yet
      push_request(dbcs_pkg::OP_BOOT,  1'b0, 1'b0, SEQ_MAX, SEQ_MAX, 1'b0); // no valid bank
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b1);       // outcome while idle
      push_request(dbcs_pkg::OP_BOOT,  1'b1, 1'b0, SEQ_MAX, '0, 1'b0);  // A only, top sequence
      push_request(dbcs_pkg::OP_SAVE,  1'b0, 1'b0, '0, '0, 1'b0);       // writes B, wraps
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b0);       // fallback to A
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b1);
      push_request(dbcs_pkg::OP_TAKE,  1'b0, 1'b0, '0, '0, 1'b0);       // saved
      push_request(dbcs_pkg::OP_BOOT,  1'b1, 1'b1, 32'd5, 32'd5, 1'b0); // tie goes to A
      push_request(dbcs_pkg::OP_BOOT,  1'b1, 1'b1, 32'd3, 32'd7, 1'b0); // B is newer
      push_request(dbcs_pkg::OP_BOOT,  1'b0, 1'b1, SEQ_MAX, '0, 1'b0);  // B only
      push_request(dbcs_pkg::OP_SAVE,  1'b0, 1'b0, '0, '0, 1'b0);
      // A boot report during a save moves the active bank; the target stays.
      push_request(dbcs_pkg::OP_BOOT,  1'b1, 1'b1, SEQ_MAX, '0, 1'b0);
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b0);       // both banks failed
      push_request(dbcs_pkg::OP_TAKE,  1'b0, 1'b0, '0, '0, 1'b0);
      push_request(OP_SPARE_LO, 1'b1, 1'b1, SEQ_MAX, SEQ_MAX, 1'b1);
      push_request(OP_SPARE_HI, 1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_DIRTY, 1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_TICK,  1'b0, 1'b0, '0, '0, 1'b0);       // far below debounce

      // With a zero debounce the pending dirty mark fires on the next request.
      write_debounce('0);
      push_request(dbcs_pkg::OP_TICK,  1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_DIRTY, 1'b0, 1'b0, '0, '0, 1'b0);       // recorded during a save
      push_request(dbcs_pkg::OP_SAVE,  1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b1);       // next save starts
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b1);

      // Random traffic, short debounce so automatic saves are frequent.
      write_debounce(dbcs_pkg::DEB_BITS'($urandom_range(12, 1)));
      push_random(RANDOM_ITEMS);

      // Sender idles more than the receiver; debounce at its maximum.
      wait_drained();
      req_gap_pct <= 66;
      rsp_gap_pct <= 11;
      write_debounce({dbcs_pkg::DEB_BITS{1'b1}});
      push_random(RANDOM_ITEMS);

      // No idling on either side, with the long receiver hold-off inside.
      wait_drained();
      req_gap_pct <= 0;
      rsp_gap_pct <= 0;
      write_debounce(dbcs_pkg::DEB_BITS'($urandom_range(30)));
      hold_arm <= 1'b1;
      push_random(RANDOM_ITEMS);

      // The dirty age runs past the debounce while a save is in flight, so a
      // second save starts as soon as the first one ends.
      write_debounce(dbcs_pkg::DEB_BITS'(100));
      push_request(dbcs_pkg::OP_SAVE,  1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_DIRTY, 1'b0, 1'b0, '0, '0, 1'b0);
      repeat (AGE_BURST) push_request(dbcs_pkg::OP_TICK, 1'b0, 1'b0, '0, '0, 1'b0);
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b1);
      push_request(dbcs_pkg::OP_WRITE, 1'b0, 1'b0, '0, '0, 1'b1);
      push_request(dbcs_pkg::OP_TAKE,  1'b0, 1'b0, '0, '0, 1'b0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
